/* rtl/ttlc_pkg.sv */
// Package for the TTL register cache: operation codes, CSR indices, entry
// status codes, sequencer states and reset defaults. No dependencies.
package ttlc_pkg;

   localparam int DefEntries = 64;
   localparam logic [31:0] DefTtlMs = 32'd1000;

   localparam logic [2:0] OP_LOOKUP   = 3'd0;
   localparam logic [2:0] OP_STORE    = 3'd1;
   localparam logic [2:0] OP_MARK_ERR = 3'd2;
   localparam logic [2:0] OP_INVAL    = 3'd3;
   localparam logic [2:0] OP_INVAL_IF = 3'd4;
   localparam logic [2:0] OP_CLEAR    = 3'd5;
   localparam logic [2:0] OP_RST_STAT = 3'd6;

   localparam logic [0:0] CSR_ENABLE = 1'b0;
   localparam logic [0:0] CSR_TTL    = 1'b1;

   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_VALID = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_ACT,
      S_RESP
   } state_type;

endpackage

/* rtl/ttlc_mem.sv */
// Entry store of the TTL register cache: one synchronous memory holding
// key, value, stamp and hit count, with a registered read. Uses ttlc_pkg.
module ttlc_mem #(
   parameter int ENTRIES = ttlc_pkg::DefEntries,
   parameter int AW = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [119:0]  wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [119:0]  rd_data
);

   logic [119:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/ttl_register_cache.sv */
// Top level of the TTL register cache: handshake, scan sequencer, status
// flags and statistics. Depends on ttlc_pkg and ttlc_mem.
//
//   Channel  Direction  Handshake          Content
//   req_     in         req_valid/ready    operation kind, key, value, time
//   rsp_     out        rsp_valid/ready    hit, value, entry hits, counters
//   csr_     in         csr_wr_en          enable and TTL registers
//
// Each item runs through these states in order: S_SCAN issues one read per
// slot (one read port), S_LAST takes the last read word, S_ACT makes the
// write-back and registers the response, S_RESP holds the response, and
// S_IDLE takes the next item. The scan finds the key, the first empty slot
// and the oldest stamp. Clear, statistics reset and interface invalidation
// also run the scan, for a uniform latency.
// Reset is synchronous and clears status flags and counters at once; the
// memory contents need no clearing. A stalled response holds its register,
// and a new item is taken once the response has been taken.
module ttl_register_cache #(
   parameter int ENTRIES = ttlc_pkg::DefEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_iface,
   input  logic [7:0]  req_slave,
   input  logic [7:0]  req_func_code,
   input  logic [15:0] req_reg_addr,
   input  logic [15:0] req_data_value,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [15:0] rsp_cached_value,
   output logic [31:0] rsp_entry_hit_count,
   output logic [31:0] rsp_lookup_total,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count,
   output logic [31:0] rsp_eviction_count,
   output logic [31:0] rsp_error_count,
   output logic [6:0]  rsp_slots_in_use,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FullCount = CW'(ENTRIES);
   localparam logic [AW-1:0] LastSlot = AW'(ENTRIES - 1);

   // Status of each slot lives in flip-flops so reset empties them at once.
   logic [1:0] status_ff [ENTRIES];

   ttlc_pkg::state_type state_ff, state_in;

   logic        enabled_ff;
   logic [31:0] ttl_ff;

   logic [2:0]  kind_ff;
   logic [39:0] key_ff;
   logic [15:0] dval_ff;
   logic [31:0] now_ff;

   logic [AW-1:0] addr_ff, addr_in;   // read address being issued
   logic [AW-1:0] cur_ff;             // slot whose data is on rd_data
   logic          found_ff;
   logic [AW-1:0] found_idx_ff;
   logic [31:0]   found_hits_ff, found_stamp_ff;
   logic [15:0]   found_data_ff;
   logic          empty_ok_ff;
   logic [AW-1:0] empty_idx_ff;
   logic [AW-1:0] old_idx_ff;
   logic [31:0]   old_stamp_ff;

   logic [31:0] req_cnt_ff, hit_cnt_ff, miss_cnt_ff, evict_cnt_ff, err_cnt_ff;
   logic [CW-1:0] used_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [119:0]  wr_data, rd_data;

   logic        rsp_valid_ff, hit_ff;
   logic [15:0] cval_ff;
   logic [31:0] ehits_ff;

   ttlc_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Memory word: key [119:80], value [79:64], stamp [63:32], hits [31:0].
   logic [39:0] rd_key;
   logic [31:0] rd_stamp;
   logic        cur_occ, cur_match, lookup_hit;
   logic [31:0] age;

   assign rd_key    = rd_data[119:80];
   assign rd_stamp  = rd_data[63:32];
   assign cur_occ   = (status_ff[cur_ff] != ttlc_pkg::ST_EMPTY);
   assign cur_match = cur_occ && (rd_key == key_ff);
   assign age       = now_ff - found_stamp_ff;
   assign lookup_hit = found_ff && (status_ff[found_idx_ff] == ttlc_pkg::ST_VALID)
                       && ((ttl_ff == 32'd0) || (age < ttl_ff));

   assign req_ready = (state_ff == ttlc_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = hit_ff;
   assign rsp_cached_value = cval_ff;
   assign rsp_entry_hit_count = ehits_ff;
   assign rsp_lookup_total = req_cnt_ff;
   assign rsp_hit_count = hit_cnt_ff;
   assign rsp_miss_count = miss_cnt_ff;
   assign rsp_eviction_count = evict_cnt_ff;
   assign rsp_error_count = err_cnt_ff;
   assign rsp_slots_in_use = 7'(used_ff);

   // Sequencer next state and write-back.
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      wr_en    = 1'b0;
      wr_addr  = found_idx_ff;
      wr_data  = '0;
      unique case (state_ff)
         ttlc_pkg::S_IDLE: begin
            addr_in = '0;
            if (req_valid) begin
               state_in = ttlc_pkg::S_SCAN;
            end
         end
         ttlc_pkg::S_SCAN: begin
            if (addr_ff == LastSlot) begin
               state_in = ttlc_pkg::S_LAST;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ttlc_pkg::S_LAST: begin
            state_in = ttlc_pkg::S_ACT;
         end
         ttlc_pkg::S_ACT: begin
            state_in = ttlc_pkg::S_RESP;
            if (kind_ff == ttlc_pkg::OP_LOOKUP && enabled_ff && lookup_hit) begin
               wr_en   = 1'b1;
               wr_addr = found_idx_ff;
               wr_data = {key_ff, found_data_ff, found_stamp_ff, found_hits_ff + 32'd1};
            end else if (kind_ff == ttlc_pkg::OP_STORE) begin
               wr_en = 1'b1;
               if (found_ff) begin
                  wr_addr = found_idx_ff;
                  wr_data = {key_ff, dval_ff, now_ff, found_hits_ff};
               end else begin
                  wr_addr = empty_ok_ff ? empty_idx_ff : old_idx_ff;
                  wr_data = {key_ff, dval_ff, now_ff, 32'd0};
               end
            end
         end
         ttlc_pkg::S_RESP: begin
            if (rsp_ready) begin
               state_in = ttlc_pkg::S_IDLE;
            end
         end
         default: state_in = ttlc_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttlc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      addr_ff <= addr_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         ttl_ff     <= ttlc_pkg::DefTtlMs;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ttlc_pkg::CSR_ENABLE: enabled_ff <= csr_wr_data[0];
            ttlc_pkg::CSR_TTL:    ttl_ff     <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Item capture and scan bookkeeping.
   always_ff @(posedge clock) begin
      if (state_ff == ttlc_pkg::S_IDLE && req_valid) begin
         kind_ff  <= req_kind;
         key_ff   <= {req_iface, req_slave, req_func_code, req_reg_addr};
         dval_ff  <= req_data_value;
         now_ff   <= req_time_ms;
         found_ff <= 1'b0;
         empty_ok_ff <= 1'b0;
         old_idx_ff  <= '0;
         old_stamp_ff <= '1;
      end
      cur_ff <= addr_ff;
      if (state_ff == ttlc_pkg::S_SCAN && addr_ff != '0
          || state_ff == ttlc_pkg::S_LAST) begin
         if (cur_match && !found_ff) begin
            found_ff       <= 1'b1;
            found_idx_ff   <= cur_ff;
            found_hits_ff  <= rd_data[31:0];
            found_stamp_ff <= rd_stamp;
            found_data_ff  <= rd_data[79:64];
         end
         if (!cur_occ && !empty_ok_ff) begin
            empty_ok_ff  <= 1'b1;
            empty_idx_ff <= cur_ff;
         end
         // Oldest stamp, lowest index on ties; the first slot seeds it when occupied.
         if (cur_occ && (rd_stamp < old_stamp_ff || cur_ff == '0)) begin
            old_stamp_ff <= rd_stamp;
            old_idx_ff   <= cur_ff;
         end
      end
   end

   // Status flags, counters and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            status_ff[i] <= ttlc_pkg::ST_EMPTY;
         end
         req_cnt_ff   <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         err_cnt_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ttlc_pkg::S_RESP && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ttlc_pkg::S_ACT) begin
            rsp_valid_ff <= 1'b1;
            hit_ff   <= 1'b0;
            cval_ff  <= '0;
            ehits_ff <= '0;
            unique case (kind_ff)
               ttlc_pkg::OP_LOOKUP: begin
                  if (enabled_ff) begin
                     req_cnt_ff <= req_cnt_ff + 32'd1;
                     if (lookup_hit) begin
                        hit_cnt_ff <= hit_cnt_ff + 32'd1;
                        hit_ff   <= 1'b1;
                        cval_ff  <= found_data_ff;
                        ehits_ff <= found_hits_ff + 32'd1;
                     end else begin
                        miss_cnt_ff <= miss_cnt_ff + 32'd1;
                     end
                  end
               end
               ttlc_pkg::OP_STORE: begin
                  if (found_ff) begin
                     status_ff[found_idx_ff] <= ttlc_pkg::ST_VALID;
                  end else if (empty_ok_ff) begin
                     status_ff[empty_idx_ff] <= ttlc_pkg::ST_VALID;
                     if (used_ff != FullCount) used_ff <= used_ff + CW'(1);
                  end else begin
                     status_ff[old_idx_ff] <= ttlc_pkg::ST_VALID;
                     evict_cnt_ff <= evict_cnt_ff + 32'd1;
                  end
               end
               ttlc_pkg::OP_MARK_ERR: begin
                  err_cnt_ff <= err_cnt_ff + 32'd1;
                  if (found_ff) status_ff[found_idx_ff] <= ttlc_pkg::ST_ERROR;
               end
               ttlc_pkg::OP_INVAL: begin
                  if (found_ff) begin
                     status_ff[found_idx_ff] <= ttlc_pkg::ST_EMPTY;
                     if (used_ff != '0) used_ff <= used_ff - CW'(1);
                  end
               end
               ttlc_pkg::OP_CLEAR: begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     status_ff[i] <= ttlc_pkg::ST_EMPTY;
                  end
                  used_ff <= '0;
               end
               ttlc_pkg::OP_RST_STAT: begin
                  req_cnt_ff   <= '0;
                  hit_cnt_ff   <= '0;
                  miss_cnt_ff  <= '0;
                  evict_cnt_ff <= '0;
                  err_cnt_ff   <= '0;
               end
               default: ;
            endcase
         end
         // Interface invalidation works slot by slot during the scan.
         if (kind_ff == ttlc_pkg::OP_INVAL_IF &&
             (state_ff == ttlc_pkg::S_SCAN && addr_ff != '0
              || state_ff == ttlc_pkg::S_LAST) &&
             cur_occ && rd_key[39:32] == key_ff[39:32]) begin
            status_ff[cur_ff] <= ttlc_pkg::ST_EMPTY;
            if (used_ff != '0) used_ff <= used_ff - CW'(1);
         end
      end
   end

endmodule
